@@ rtl/pwba_pkg.sv @@
// ----------------------------------------------------------------------------
// pwba_pkg: shared types and constants for the window allocator
// Command, status and window codes, shared-unit operations and the structs
// passed between the sequencer and the window register file.
// ----------------------------------------------------------------------------
package pwba_pkg;

	localparam int unsigned NUM_WIN   = 3;
	localparam int unsigned SPACE_LSB = 24;
	localparam logic [63:0] LOW_GUARD = 64'h0000_0000_0000_1000;

	typedef logic [1:0] win_idx_t;

	localparam win_idx_t WIN_IO    = 2'd0;
	localparam win_idx_t WIN_MEM   = 2'd1;
	localparam win_idx_t WIN_MEM64 = 2'd2;

	localparam logic [1:0] SPACE_NONE = 2'd0;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_GET   = 2'd2,
		CMD_XLATE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_WINDOW = 2'd1,
		STATUS_NO_FIT    = 2'd2,
		STATUS_NOT_ALLOC = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_OR  = 2'd2
	} alu_op_t;

	// write requests into the window register file
	typedef struct packed {
		logic        load_en;
		win_idx_t    load_idx;
		logic [63:0] load_bus;
		logic [63:0] load_host;
		logic [63:0] load_size;
		logic [63:0] load_off;
		logic        off_en;
		win_idx_t    off_idx;
		logic [63:0] off_val;
	} win_wr_t;

	// contents of the selected window
	typedef struct packed {
		logic [63:0] bus;
		logic [63:0] host;
		logic [63:0] size;
		logic [63:0] off;
	} win_rd_t;

endpackage

@@ rtl/pwba_if.sv @@
// ----------------------------------------------------------------------------
// pwba_req_if / pwba_rsp_if: request and result channels
// Valid/ready channels; an item moves on an edge where both are high.
// ----------------------------------------------------------------------------
interface pwba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] range_flags;
	logic [63:0] range_bus_addr;
	logic [63:0] range_host_addr;
	logic [63:0] range_length;
	logic        is_mem;
	logic        is_mem64;
	logic [63:0] amount;
	logic [63:0] bus_address_in;

	modport source (
		output valid, command, range_flags, range_bus_addr, range_host_addr,
		       range_length, is_mem, is_mem64, amount, bus_address_in,
		input  ready
	);
	modport sink (
		input  valid, command, range_flags, range_bus_addr, range_host_addr,
		       range_length, is_mem, is_mem64, amount, bus_address_in,
		output ready
	);
endinterface

interface pwba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] address;

	modport source (output valid, status, address, input ready);
	modport sink (input valid, status, address, output ready);
endinterface

@@ rtl/pwba_alu.sv @@
// ----------------------------------------------------------------------------
// pwba_alu: shared 64-bit arithmetic unit
// One adder/subtractor with borrow out, plus a bitwise OR path.
// ----------------------------------------------------------------------------
module pwba_alu (
	input  pwba_pkg::alu_op_t op,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output logic [63:0]       y,
	output logic              borrow
);
	import pwba_pkg::*;

	logic        sub;
	logic [63:0] b_x;
	logic [64:0] sum;

	assign sub = (op == ALU_SUB);
	assign b_x = sub ? ~b : b;
	assign sum = {1'b0, a} + {1'b0, b_x} + {64'd0, sub};

	always_comb begin
		unique case (op)
			ALU_OR:  y = a | b;
			default: y = sum[63:0];
		endcase
	end

	// subtract: no carry out means a < b
	assign borrow = sub & ~sum[64];

endmodule

@@ rtl/pwba_win_regs.sv @@
// ----------------------------------------------------------------------------
// pwba_win_regs: window register file
// Three windows of bus start, host start, size and next offset.
// ----------------------------------------------------------------------------
module pwba_win_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  pwba_pkg::win_wr_t wr,
	input  pwba_pkg::win_idx_t rd_idx,
	output pwba_pkg::win_rd_t rd,
	output logic [2:0]        present
);
	import pwba_pkg::*;

	logic [63:0] bus_q  [NUM_WIN];
	logic [63:0] host_q [NUM_WIN];
	logic [63:0] size_q [NUM_WIN];
	logic [63:0] off_q  [NUM_WIN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN; i++) begin
				bus_q[i]  <= '0;
				host_q[i] <= '0;
				size_q[i] <= '0;
				off_q[i]  <= '0;
			end
		end else begin
			if (wr.load_en) begin
				bus_q[wr.load_idx]  <= wr.load_bus;
				host_q[wr.load_idx] <= wr.load_host;
				size_q[wr.load_idx] <= wr.load_size;
				off_q[wr.load_idx]  <= wr.load_off;
			end
			if (wr.off_en) begin
				off_q[wr.off_idx] <= wr.off_val;
			end
		end
	end

	always_comb begin
		unique case (rd_idx)
			WIN_IO:    rd = '{bus: bus_q[0], host: host_q[0], size: size_q[0], off: off_q[0]};
			WIN_MEM:   rd = '{bus: bus_q[1], host: host_q[1], size: size_q[1], off: off_q[1]};
			WIN_MEM64: rd = '{bus: bus_q[2], host: host_q[2], size: size_q[2], off: off_q[2]};
			default:   rd = '0;
		endcase
	end

	assign present = {size_q[2] != '0, size_q[1] != '0, size_q[0] != '0};

endmodule

@@ rtl/pcie_window_bar_allocator.sv @@
// Each accepted item steps through decode, its arithmetic states and finish; a load, a request that
// finds no window and a zero translate go straight from decode to finish.
// Ready is high only while idle, so a new item is taken only once the last result is in the output
// register; a held result keeps the sequencer in its last step until the output register frees up.
// All arithmetic goes through the single shared 64-bit adder, one operation a cycle. Reset
// clears all windows to absent with zero offset, drops any pending result and idles.
// ----------------------------------------------------------------------------
// pcie_window_bar_allocator: aligned bump allocator over three bus windows
// Loads IO, 32-bit and 64-bit memory windows, hands out power-of-two aligned
// blocks, reports aligned bases and translates bus to host addresses.
// ----------------------------------------------------------------------------
module pcie_window_bar_allocator (
	input logic        clk,
	input logic        arst_n,
	pwba_req_if.sink   req,
	pwba_rsp_if.source rsp
);
	import pwba_pkg::*;

	// One-hot sequencer; each arithmetic state issues exactly one ALU operation.
	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0_0000_0000_0001,
		ST_DECODE   = 13'b0_0000_0000_0010,
		ST_ADD_OFF  = 13'b0_0000_0000_0100,
		ST_DEC_ONE  = 13'b0_0000_0000_1000,
		ST_MASK     = 13'b0_0000_0001_0000,
		ST_OR_MASK  = 13'b0_0000_0010_0000,
		ST_INC_ONE  = 13'b0_0000_0100_0000,
		ST_SUB_BASE = 13'b0_0000_1000_0000,
		ST_ADD_AMT  = 13'b0_0001_0000_0000,
		ST_CHECK    = 13'b0_0010_0000_0000,
		ST_XL_SUB   = 13'b0_0100_0000_0000,
		ST_XL_ADD   = 13'b0_1000_0000_0000,
		ST_FINISH   = 13'b1_0000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// captured item
	cmd_t        cmd_q;
	logic [1:0]  space_q;
	logic [63:0] rbus_q;
	logic [63:0] rhost_q;
	logic [63:0] rlen_q;
	logic        is_mem_q;
	logic        is_mem64_q;
	logic [63:0] amount_q;
	logic [63:0] busin_q;

	// working registers
	win_idx_t    win_q;
	logic [63:0] acc_q;
	logic [63:0] mask_q;
	logic [63:0] aligned_q;
	status_t     res_status_q;
	logic [63:0] res_addr_q;

	// output register
	logic        rsp_valid_q;
	status_t     rsp_status_q;
	logic [63:0] rsp_addr_q;

	// shared unit and window file hookup
	alu_op_t     alu_op;
	logic [63:0] alu_a;
	logic [63:0] alu_b;
	logic [63:0] alu_y;
	logic        alu_borrow;

	win_wr_t     win_wr;
	win_rd_t     win_rd;
	logic [2:0]  present;

	logic        has_io, has32, has64;
	logic        usable;
	win_idx_t    pick;
	logic        slot_free;
	logic        req_fire;

	pwba_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	pwba_win_regs u_win_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (win_wr),
		.rd_idx  (win_q),
		.rd      (win_rd),
		.present (present)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;

	// Window choice: the 64-bit window wins when asked for and present, or when
	// it is the only memory window; any other memory request goes to 32-bit.
	assign has_io = present[0];
	assign has32  = present[1];
	assign has64  = present[2];

	always_comb begin
		priority if (is_mem_q && ((is_mem64_q && has64) || (has64 && !has32))) begin
			pick = WIN_MEM64;
		end else if (is_mem_q) begin
			pick = WIN_MEM;
		end else begin
			pick = WIN_IO;
		end
	end

	assign usable = is_mem_q ? (has64 || has32) : has_io;

	// Operand selection for the shared unit, one step per state.
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = acc_q;
		alu_b  = 64'd1;
		unique case (state_q)
			ST_ADD_OFF: begin
				alu_a = win_rd.bus;
				alu_b = win_rd.off;
			end
			ST_DEC_ONE: begin
				alu_op = ALU_SUB;
			end
			ST_MASK: begin
				alu_op = ALU_SUB;
				alu_a  = amount_q;
			end
			ST_OR_MASK: begin
				alu_op = ALU_OR;
				alu_b  = mask_q;
			end
			ST_SUB_BASE: begin
				alu_op = ALU_SUB;
				alu_a  = aligned_q;
				alu_b  = win_rd.bus;
			end
			ST_ADD_AMT: begin
				alu_b = amount_q;
			end
			ST_CHECK: begin
				// size - end borrows exactly when the block overruns the window
				alu_op = ALU_SUB;
				alu_a  = win_rd.size;
				alu_b  = acc_q;
			end
			ST_XL_SUB: begin
				alu_op = ALU_SUB;
				alu_a  = busin_q;
				alu_b  = win_rd.bus;
			end
			ST_XL_ADD: begin
				alu_a = win_rd.host;
				alu_b = acc_q;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	// Window file writes: whole-window load, or an offset bump after a fit.
	always_comb begin
		win_wr           = '0;
		win_wr.load_idx  = space_q - 2'd1;
		win_wr.load_bus  = rbus_q;
		win_wr.load_host = rhost_q;
		win_wr.load_size = rlen_q;
		win_wr.load_off  = (rbus_q < LOW_GUARD) ? LOW_GUARD : 64'd0;
		win_wr.load_en   = (state_q == ST_DECODE) && (cmd_q == CMD_LOAD)
		                   && (space_q != SPACE_NONE);
		win_wr.off_idx   = win_q;
		win_wr.off_val   = acc_q;
		win_wr.off_en    = (state_q == ST_CHECK) && !alu_borrow;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (req_fire) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (cmd_q)
					CMD_LOAD:  state_d = ST_FINISH;
					CMD_XLATE: state_d = (busin_q == '0) ? ST_FINISH : ST_XL_SUB;
					default:   state_d = usable ? ST_ADD_OFF : ST_FINISH;
				endcase
			end
			ST_ADD_OFF:  state_d = ST_DEC_ONE;
			ST_DEC_ONE:  state_d = ST_MASK;
			ST_MASK:     state_d = ST_OR_MASK;
			ST_OR_MASK:  state_d = ST_INC_ONE;
			ST_INC_ONE:  state_d = (cmd_q == CMD_GET) ? ST_FINISH : ST_SUB_BASE;
			ST_SUB_BASE: state_d = ST_ADD_AMT;
			ST_ADD_AMT:  state_d = ST_CHECK;
			ST_CHECK:    state_d = ST_FINISH;
			ST_XL_SUB:   state_d = ST_XL_ADD;
			ST_XL_ADD:   state_d = ST_FINISH;
			ST_FINISH:   if (slot_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the item on accept; hold it for the whole sequence.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q      <= cmd_t'(req.command);
			space_q    <= req.range_flags[SPACE_LSB +: 2];
			rbus_q     <= req.range_bus_addr;
			rhost_q    <= req.range_host_addr;
			rlen_q     <= req.range_length;
			is_mem_q   <= req.is_mem;
			is_mem64_q <= req.is_mem64;
			amount_q   <= req.amount;
			busin_q    <= req.bus_address_in;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DECODE: begin
				win_q        <= pick;
				res_addr_q   <= '0;
				priority if (cmd_q == CMD_LOAD) begin
					res_status_q <= STATUS_OK;
				end else if (cmd_q == CMD_XLATE) begin
					res_status_q <= (busin_q == '0) ? STATUS_NOT_ALLOC : STATUS_OK;
				end else begin
					res_status_q <= usable ? STATUS_OK : STATUS_NO_WINDOW;
				end
			end
			ST_ADD_OFF, ST_DEC_ONE, ST_OR_MASK, ST_SUB_BASE, ST_ADD_AMT,
			ST_XL_SUB: begin
				acc_q <= alu_y;
			end
			ST_MASK: begin
				mask_q <= alu_y;
			end
			ST_INC_ONE: begin
				aligned_q <= alu_y;
				if (cmd_q == CMD_GET) res_addr_q <= alu_y;
			end
			ST_CHECK: begin
				if (alu_borrow) begin
					res_status_q <= STATUS_NO_FIT;
				end else begin
					res_addr_q <= aligned_q;
				end
			end
			ST_XL_ADD: begin
				res_addr_q <= alu_y;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Output register: drop the result in once the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && slot_free) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= res_addr_q;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.address = rsp_addr_q;

`ifndef NO_ASSERTIONS
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_DECODE))
		else $error("accepted item did not enter decode");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != STATUS_OK)) |-> (rsp.address == '0))
		else $error("failed result carries a non-zero address");

	a_offset_only_on_fit: assert property (@(posedge clk) disable iff (!arst_n)
		win_wr.off_en |-> ((cmd_q == CMD_ALLOC) && !win_wr.load_en))
		else $error("offset written outside a fitting allocate");

	a_finish_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && slot_free) |=> (rsp.valid && (state_q == ST_IDLE)))
		else $error("finished item did not reach the output register");
`endif

endmodule

@@ test/pwba_checker.sv @@
// ----------------------------------------------------------------------------
// pwba_checker: result predictor and comparator for the window allocator
// Watches the request and result channels. Each accepted request item is run
// through a local copy of the three windows to predict its result, and each
// accepted result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pwba_checker (
	input  logic clk,
	input  logic arst_n,
	pwba_req_if  req,
	pwba_rsp_if  rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pwba_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [63:0] address;
	} win_result_t;

	logic [63:0] win_bus  [NUM_WIN];
	logic [63:0] win_host [NUM_WIN];
	logic [63:0] win_size [NUM_WIN];
	logic [63:0] win_off  [NUM_WIN];

	win_result_t expected_results[$];
	win_result_t want;
	int          mismatch_count = 0;
	int          outstanding = 0;

	assign errors  = mismatch_count;
	assign pending = outstanding;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic win_idx_t choose_window(input logic mem, input logic mem64);
		logic has64;
		logic has32;
		has64 = (win_size[WIN_MEM64] != '0);
		has32 = (win_size[WIN_MEM] != '0);
		if (mem && ((mem64 && has64) || (has64 && !has32)))
			return WIN_MEM64;
		if (mem)
			return WIN_MEM;
		return WIN_IO;
	endfunction

	// apply one item to the local windows and return its result
	function automatic win_result_t predict_window_op(
		input cmd_t        cmd,
		input logic [31:0] flags,
		input logic [63:0] rbus,
		input logic [63:0] rhost,
		input logic [63:0] rlen,
		input logic        mem,
		input logic        mem64,
		input logic [63:0] amount,
		input logic [63:0] busin
	);
		win_result_t res;
		logic [1:0]  space;
		logic        absent;
		win_idx_t    w;
		logic [63:0] cur;
		logic [63:0] aligned;
		logic [63:0] end_off;
		res.status  = STATUS_OK;
		res.address = '0;
		case (cmd)
			CMD_LOAD: begin
				space = flags[SPACE_LSB +: 2];
				if (space != SPACE_NONE) begin
					w = win_idx_t'(space - 2'd1);
					win_bus[w]  = rbus;
					win_host[w] = rhost;
					win_size[w] = rlen;
					win_off[w]  = (rbus < LOW_GUARD) ? LOW_GUARD : '0;
				end
			end
			CMD_ALLOC, CMD_GET: begin
				absent = mem ? (win_size[WIN_MEM64] == '0 && win_size[WIN_MEM] == '0)
				             : (win_size[WIN_IO] == '0);
				if (absent) begin
					res.status = STATUS_NO_WINDOW;
				end else begin
					w       = choose_window(mem, mem64);
					cur     = win_bus[w] + win_off[w];
					aligned = ((cur - 64'd1) | (amount - 64'd1)) + 64'd1;
					if (cmd == CMD_GET) begin
						res.address = aligned;
					end else begin
						end_off = aligned - win_bus[w] + amount;
						if (end_off > win_size[w]) begin
							res.status = STATUS_NO_FIT;
						end else begin
							res.address = aligned;
							win_off[w]  = end_off;
						end
					end
				end
			end
			CMD_XLATE: begin
				if (busin == '0) begin
					res.status = STATUS_NOT_ALLOC;
				end else begin
					w           = choose_window(mem, mem64);
					res.address = win_host[w] + (busin - win_bus[w]);
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			for (int i = 0; i < NUM_WIN; i++) begin
				win_bus[i]  = '0;
				win_host[i] = '0;
				win_size[i] = '0;
				win_off[i]  = '0;
			end
			outstanding = 0;
		end else begin
			// a result never arrives together with its own item, so compare before push
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding: status %0d address %h",
						rsp.status, rsp.address));
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							rsp.status, want.status));
					if (rsp.address !== want.address)
						report_mismatch($sformatf("address %h, predicted %h",
							rsp.address, want.address));
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(predict_window_op(cmd_t'(req.command),
					req.range_flags, req.range_bus_addr, req.range_host_addr,
					req.range_length, req.is_mem, req.is_mem64, req.amount,
					req.bus_address_in));
			outstanding = expected_results.size();
		end
	end

endmodule

@@ test/tb_pcie_window_bar_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_pcie_window_bar_allocator: testbench for the window allocator
// Drives a directed run over empty, ignored, low-guard and extreme windows,
// then random load, allocate, get-base and translate items under several
// idling patterns, with one long result hold-off. A checker module predicts
// and compares every result; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_pcie_window_bar_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import pwba_pkg::*;

	localparam int CLK_PERIOD       = 8;
	localparam int RESET_CYCLES     = 8;
	localparam int RANDOM_PER_PHASE = 257;
	localparam int HOLD_CYCLES      = 400;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int DRAIN_CYCLES     = 24;

	// space codes as they sit in bits 25:24 of the range flags
	localparam logic [1:0] SPACE_IO    = WIN_IO + 2'd1;
	localparam logic [1:0] SPACE_MEM   = WIN_MEM + 2'd1;
	localparam logic [1:0] SPACE_MEM64 = WIN_MEM64 + 2'd1;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] flags;
		logic [63:0] rbus;
		logic [63:0] rhost;
		logic [63:0] rlen;
		logic        mem;
		logic        mem64;
		logic [63:0] amount;
		logic [63:0] busin;
	} alloc_item_t;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;

	// idling odds in percent, changed only between phases
	int   src_idle_pct  = 0;
	int   snk_stall_pct = 0;
	// raised by the stimulus, dropped by the ready process once the hold-off is done
	logic hold_off = 1'b0;
	int   quiet_cycles = 0;

	pwba_req_if req_ch ();
	pwba_rsp_if rsp_ch ();

	pcie_window_bar_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pwba_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Fill every field at random, so that bits the command ignores still toggle.
	function automatic alloc_item_t noise_item(input cmd_t cmd);
		alloc_item_t it;
		it.command = cmd;
		it.flags   = $urandom;
		it.rbus    = rand64();
		it.rhost   = rand64();
		it.rlen    = rand64();
		it.mem     = 1'($urandom_range(1));
		it.mem64   = 1'($urandom_range(1));
		it.amount  = rand64();
		it.busin   = rand64();
		return it;
	endfunction

	function automatic alloc_item_t load_item(input logic [1:0] space, input logic [63:0] rbus,
		input logic [63:0] rhost, input logic [63:0] rlen);
		alloc_item_t it;
		it = noise_item(CMD_LOAD);
		it.flags[SPACE_LSB +: 2] = space;
		it.rbus  = rbus;
		it.rhost = rhost;
		it.rlen  = rlen;
		return it;
	endfunction

	// allocate or get-base request
	function automatic alloc_item_t req_item(input cmd_t cmd, input logic mem,
		input logic mem64, input logic [63:0] amount);
		alloc_item_t it;
		it = noise_item(cmd);
		it.mem    = mem;
		it.mem64  = mem64;
		it.amount = amount;
		return it;
	endfunction

	function automatic alloc_item_t xlate_item(input logic mem, input logic mem64,
		input logic [63:0] busin);
		alloc_item_t it;
		it = noise_item(CMD_XLATE);
		it.mem   = mem;
		it.mem64 = mem64;
		it.busin = busin;
		return it;
	endfunction

	// Mostly powers of two that fit, with zero, odd values and huge sizes mixed in.
	function automatic logic [63:0] rand_amount();
		case ($urandom_range(19))
			0:       return '0;
			1:       return rand64();
			2:       return '1;
			3:       return 64'd1 << $urandom_range(21, 63);
			default: return 64'd1 << $urandom_range(0, 20);
		endcase
	endfunction

	// Keep loads rare enough that windows fill up, and make most of them sane windows
	// so that allocations get well past the first one.
	function automatic alloc_item_t random_item();
		alloc_item_t it;
		int unsigned pick;
		logic [1:0]  space;
		logic [63:0] rbus;
		logic [63:0] rlen;
		logic        rmem;
		logic        rmem64;
		pick   = $urandom_range(99);
		rmem   = 1'($urandom_range(1));
		rmem64 = 1'($urandom_range(1));
		if (pick < 10) begin
			space = ($urandom_range(9) == 0) ? SPACE_NONE : 2'($urandom_range(1, 3));
			case ($urandom_range(3))
				0:       rbus = 64'($urandom_range(0, 'h1000));
				1:       rbus = {32'h0, $urandom} & ~64'hFFF;
				2:       rbus = rand64() & ~64'hFFFF;
				default: rbus = rand64();
			endcase
			case ($urandom_range(9))
				0:       rlen = '0;
				1:       rlen = rand64();
				2:       rlen = '1;
				default: rlen = 64'd1 << $urandom_range(12, 34);
			endcase
			it = load_item(space, rbus, rand64(), rlen);
		end else if (pick < 55) begin
			it = req_item(CMD_ALLOC, rmem, rmem64, rand_amount());
		end else if (pick < 75) begin
			it = req_item(CMD_GET, rmem, rmem64, rand_amount());
		end else begin
			case ($urandom_range(9))
				0:       it = xlate_item(rmem, rmem64, '0);
				1:       it = xlate_item(rmem, rmem64, '1);
				default: it = xlate_item(rmem, rmem64, rand64());
			endcase
		end
		return it;
	endfunction

	// Offer one item and hold it until the block takes it. Drop valid only when an
	// idle gap is due, so valid is never lowered and raised within one step.
	task automatic send_item(input alloc_item_t it);
		if ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		req_ch.valid           <= 1'b1;
		req_ch.command         <= it.command;
		req_ch.range_flags     <= it.flags;
		req_ch.range_bus_addr  <= it.rbus;
		req_ch.range_host_addr <= it.rhost;
		req_ch.range_length    <= it.rlen;
		req_ch.is_mem          <= it.mem;
		req_ch.is_mem64        <= it.mem64;
		req_ch.amount          <= it.amount;
		req_ch.bus_address_in  <= it.busin;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Result side: random stalls, or one long hold-off counted here on request.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// Watchdog: end the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_pcie_window_bar_allocator: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Start with every input known and the block in reset.
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.command         = CMD_LOAD;
		req_ch.range_flags     = '0;
		req_ch.range_bus_addr  = '0;
		req_ch.range_host_addr = '0;
		req_ch.range_length    = '0;
		req_ch.is_mem          = 1'b0;
		req_ch.is_mem64        = 1'b0;
		req_ch.amount          = '0;
		req_ch.bus_address_in  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run, no idling on either side.
		// Nothing loaded yet: requests find no window, translate of zero is refused
		// and a translate into an absent window still gives an address.
		send_item(req_item(CMD_ALLOC, 1'b0, 1'b0, 64'h100));
		send_item(req_item(CMD_GET, 1'b1, 1'b1, 64'h1000));
		send_item(xlate_item(1'b0, 1'b0, '0));
		send_item(xlate_item(1'b1, 1'b1, 64'hDEAD_BEEF_0000_1234));
		// space code none must leave the windows alone, so IO stays absent
		send_item(load_item(SPACE_NONE, '1, '1, '1));
		send_item(req_item(CMD_ALLOC, 1'b0, 1'b0, 64'h10));
		// IO window at bus zero picks up the low guard offset
		send_item(load_item(SPACE_IO, '0, 64'h0000_0000_8000_0000, 64'h1_0000));
		send_item(load_item(SPACE_MEM, 64'h4000_0000, 64'hC_4000_0000, 64'h1000_0000));
		send_item(req_item(CMD_ALLOC, 1'b1, 1'b0, 64'h1_0000));
		// 64-bit request with no 64-bit window falls back to the 32-bit one
		send_item(req_item(CMD_ALLOC, 1'b1, 1'b1, 64'h100));
		// full-range 64-bit window at the top of the bus: everything wraps
		send_item(load_item(SPACE_MEM64, '1, '1, '1));
		send_item(req_item(CMD_ALLOC, 1'b1, 1'b1, 64'h1));
		send_item(req_item(CMD_GET, 1'b1, 1'b1, 64'd1 << 63));
		send_item(req_item(CMD_ALLOC, 1'b0, 1'b0, 64'h100));
		send_item(req_item(CMD_GET, 1'b0, 1'b1, 64'h1));
		// too large for the IO window
		send_item(req_item(CMD_ALLOC, 1'b0, 1'b0, 64'd1 << 63));
		// zero, odd and all-ones amounts go through the rounding as they stand
		send_item(req_item(CMD_ALLOC, 1'b1, 1'b0, '0));
		send_item(req_item(CMD_ALLOC, 1'b1, 1'b0, 64'h3));
		send_item(req_item(CMD_GET, 1'b0, 1'b0, '1));
		send_item(xlate_item(1'b1, 1'b1, '1));
		send_item(xlate_item(1'b0, 1'b0, 64'h1004));
		// drop the 32-bit window (bus just below the guard), so plain memory goes 64-bit
		send_item(load_item(SPACE_MEM, 64'h0FFF, '0, '0));
		send_item(req_item(CMD_ALLOC, 1'b1, 1'b0, 64'h1000));
		// drop the 64-bit window too (bus right on the guard): no memory window left
		send_item(load_item(SPACE_MEM64, 64'h1000, '0, '0));
		send_item(req_item(CMD_GET, 1'b1, 1'b1, 64'h1));

		// Random run in four idling phases; hold the result side off once while the
		// sender keeps offering, so the block fills and stalls its input.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 54;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 54;
					hold_off      = 1'b1;
				end
				default: begin
					src_idle_pct  = 33;
					snk_stall_pct = 33;
				end
			endcase
			repeat (RANDOM_PER_PHASE) send_item(random_item());
		end
		req_ch.valid <= 1'b0;

		// Drain: wait for every predicted result, then give the block time to show
		// any stray one. Sample on the falling edge, clear of the checker's updates.
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("tb_pcie_window_bar_allocator: clean");
		end else begin
			$display("tb_pcie_window_bar_allocator: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pwba_pkg.sv
rtl/pwba_if.sv
rtl/pwba_alu.sv
rtl/pwba_win_regs.sv
rtl/pcie_window_bar_allocator.sv
test/pwba_checker.sv
test/tb_pcie_window_bar_allocator.sv
